### hdl/bba_pkg.sv
// Shared types and codes for the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;

  // Request kinds carried on the input tuser bit.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ST_NO_MEM    = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEAP_BASE  = 2'd0;
  localparam logic [1:0] REG_HEAP_ORDER = 2'd1;

  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int ORDER_W = 5;

  // Fixed-width part of one result.
  typedef struct packed {
    logic [ORDER_W-1:0] block_order;
    logic [ADDR_W-1:0]  alloc_addr;
    logic [2:0]         status;
  } res_t;

endpackage

### hdl/buddy_block_allocator_top.sv
// Top level of the buddy block allocator: ports, configuration, memories, result register.
`timescale 1ns / 1ps
// The block manages a heap of 2^heap_order bytes at heap_base and serves one request at a
// time. An allocate request (tuser 0) returns a pointer past a header of HEADER_BYTES, taken
// from the lowest-address free block of the smallest fitting order; a free request (tuser 1)
// releases a pointer and merges free buddies upward. The free-node map and the granule tag
// table live in block RAMs with registered reads, so the request time is set by how many map
// entries are read: an allocate scans map nodes at the chosen order (up to 2^(heap_order-order)
// nodes) and then splits down one level at a time; a free merges upward one level at a time.
// After reset and after every write to the heap base or heap order register the block
// clears both memories and accepts no request until that pass is done. Each finished result
// waits in an output register, and the next request is accepted while it waits.
module buddy_block_allocator_top
  import bba_pkg::*;
#(
  parameter int HEAP_ORDER_MAX = 16,
  parameter int MIN_ORDER      = 5,
  parameter int HEADER_BYTES   = 16,
  localparam int U_W   = HEAP_ORDER_MAX + 1,
  localparam int OUT_W = ((3 + ADDR_W + ORDER_W + 2 * U_W) + 7) / 8 * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [47:0]       cfg_wdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [79:0]       s_tdata,   // req_size[31:0], free_addr[79:32]
  input  logic              s_tuser,   // cmd
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // status, alloc_addr, block_order, used_bytes, free_bytes
);

  localparam int GRAN_W = HEAP_ORDER_MAX - MIN_ORDER;
  localparam int NODE_W = GRAN_W + 1;
  localparam int ORD_W  = $clog2(HEAP_ORDER_MAX + 1);

  logic [ADDR_W-1:0]  heap_base;
  logic [ORDER_W-1:0] heap_order;
  logic [ORDER_W-1:0] eff_order;
  logic               cfg_hit;
  logic               out_free;
  logic               res_valid;
  res_t               res;
  logic [U_W-1:0]     used;
  res_t               out_res;
  logic [U_W-1:0]     out_used;
  logic [U_W-1:0]     out_freeb;

  logic               fm_we;
  logic [NODE_W-1:0]  fm_waddr;
  logic               fm_wdata;
  logic [NODE_W-1:0]  fm_raddr;
  logic               fm_rdata;
  logic               tg_we;
  logic [GRAN_W-1:0]  tg_waddr;
  logic [ORDER_W-1:0] tg_wdata;
  logic [GRAN_W-1:0]  tg_raddr;
  logic [ORDER_W-1:0] tg_rdata;

  // Any write to a known register reinitializes the heap.
  assign cfg_hit = cfg_we &&
                   (cfg_index == REG_HEAP_BASE || cfg_index == REG_HEAP_ORDER);

  // The heap order is clamped into the range the tree supports.
  always_comb begin
    if (heap_order < ORDER_W'(MIN_ORDER)) begin
      eff_order = ORDER_W'(MIN_ORDER);
    end else if (heap_order > ORDER_W'(HEAP_ORDER_MAX)) begin
      eff_order = ORDER_W'(HEAP_ORDER_MAX);
    end else begin
      eff_order = heap_order;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_order <= ORDER_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAP_BASE:  heap_base  <= cfg_wdata;
        REG_HEAP_ORDER: heap_order <= cfg_wdata[ORDER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bba_ram #(.WIDTH(1), .DEPTH(2 ** NODE_W)) u_free_map (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  bba_ram #(.WIDTH(ORDER_W), .DEPTH(2 ** GRAN_W)) u_alloc_tag (
    .clk   (clk),
    .we    (tg_we),
    .waddr (tg_waddr),
    .wdata (tg_wdata),
    .raddr (tg_raddr),
    .rdata (tg_rdata)
  );

  bba_seq #(
    .HEAP_ORDER_MAX (HEAP_ORDER_MAX),
    .MIN_ORDER      (MIN_ORDER),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start_clear (cfg_hit),
    .h           (eff_order[ORD_W-1:0]),
    .base        (heap_base),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (s_tuser),
    .in_size     (s_tdata[31:0]),
    .in_ptr      (s_tdata[79:32]),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res),
    .used        (used),
    .fm_we       (fm_we),
    .fm_waddr    (fm_waddr),
    .fm_wdata    (fm_wdata),
    .fm_raddr    (fm_raddr),
    .fm_rdata    (fm_rdata),
    .tg_we       (tg_we),
    .tg_waddr    (tg_waddr),
    .tg_wdata    (tg_wdata),
    .tg_raddr    (tg_raddr),
    .tg_rdata    (tg_rdata)
  );

  // Output register: a finished request's result waits here until taken.
  assign out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res   <= res;
      out_used  <= used;
      out_freeb <= (U_W'(1) << eff_order) - used;
    end
  end

  assign m_tdata = OUT_W'({out_freeb, out_used, out_res.block_order,
                           out_res.alloc_addr, out_res.status});

endmodule

### hdl/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bba_seq.sv
// Request sequencer: allocation search and split, free check and merge, heap clearing.
`timescale 1ns / 1ps
module bba_seq
  import bba_pkg::*;
#(
  parameter int HEAP_ORDER_MAX = 16,
  parameter int MIN_ORDER      = 5,
  parameter int HEADER_BYTES   = 16,
  localparam int GRAN_W = HEAP_ORDER_MAX - MIN_ORDER,
  localparam int NODE_W = GRAN_W + 1,
  localparam int ORD_W  = $clog2(HEAP_ORDER_MAX + 1),
  localparam int U_W    = HEAP_ORDER_MAX + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start_clear,
  input  logic [ORD_W-1:0]     h,
  input  logic [ADDR_W-1:0]    base,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [SIZE_W-1:0]    in_size,
  input  logic [ADDR_W-1:0]    in_ptr,
  input  logic                 out_free,
  output logic                 res_valid,
  output res_t                 res,
  output logic [U_W-1:0]       used,
  output logic                 fm_we,
  output logic [NODE_W-1:0]    fm_waddr,
  output logic                 fm_wdata,
  output logic [NODE_W-1:0]    fm_raddr,
  input  logic                 fm_rdata,
  output logic                 tg_we,
  output logic [GRAN_W-1:0]    tg_waddr,
  output logic [ORDER_W-1:0]   tg_wdata,
  output logic [GRAN_W-1:0]    tg_raddr,
  input  logic [ORDER_W-1:0]   tg_rdata
);

  localparam int CNT_W = GRAN_W + 1;
  localparam int NORD  = 2 ** ORD_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_A_SIZE = 4'd2;
  localparam logic [3:0] S_A_ORD  = 4'd3;
  localparam logic [3:0] S_A_RD   = 4'd4;
  localparam logic [3:0] S_A_CHK  = 4'd5;
  localparam logic [3:0] S_SPLIT  = 4'd6;
  localparam logic [3:0] S_A_TAG  = 4'd7;
  localparam logic [3:0] S_F_ADDR = 4'd8;
  localparam logic [3:0] S_F_TAG  = 4'd9;
  localparam logic [3:0] S_M_RD   = 4'd10;
  localparam logic [3:0] S_M_CHK  = 4'd11;
  localparam logic [3:0] S_M_SET  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]                state;
  logic [NODE_W-1:0]         ccnt;
  logic [NODE_W-1:0]         nidx;
  logic [ORD_W-1:0]          ord;
  logic [ORD_W-1:0]          kord;
  logic [SIZE_W-1:0]         size_q;
  logic [ADDR_W-1:0]         ptr_q;
  logic [HEAP_ORDER_MAX-1:0] blk;
  logic [CNT_W-1:0]          cnt [NORD];
  logic [U_W-1:0]            used_total;

  // Allocation sizing.
  logic [SIZE_W:0]           need;
  logic                      size_bad;
  logic [ORD_W-1:0]          k_calc;
  // Order search.
  logic                      ord_found;
  logic [ORD_W-1:0]          ord_first;
  // Address arithmetic.
  logic [NODE_W-1:0]         rel;
  logic [HEAP_ORDER_MAX-1:0] off_blk;
  logic [ADDR_W-1:0]         off48;
  logic                      off_bad;
  logic [HEAP_ORDER_MAX-1:0] blk_calc;
  logic [HEAP_ORDER_MAX-1:0] tmask;
  logic                      tag_bad;
  logic [NODE_W-1:0]         leaf_idx;
  logic [U_W-1:0]            tsize;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE) && out_free;
  assign used      = used_total;

  always_comb begin
    need     = {1'b0, size_q} + (SIZE_W+1)'(HEADER_BYTES);
    size_bad = (size_q == '0) || (need > ((SIZE_W+1)'(1) << h));
    k_calc   = ORD_W'(HEAP_ORDER_MAX);
    for (int o = HEAP_ORDER_MAX - 1; o >= MIN_ORDER; o--) begin
      if (need <= ((SIZE_W+1)'(1) << o)) begin
        k_calc = ORD_W'(o);
      end
    end
  end

  always_comb begin
    ord_found = 1'b0;
    ord_first = '0;
    for (int j = NORD - 1; j >= 0; j--) begin
      if (ORD_W'(j) >= kord && ORD_W'(j) <= h && cnt[j] != '0) begin
        ord_found = 1'b1;
        ord_first = ORD_W'(j);
      end
    end
  end

  always_comb begin
    rel      = nidx - (NODE_W'(1) << (h - kord));
    off_blk  = HEAP_ORDER_MAX'(rel) << kord;
    off48    = ptr_q - base;
    off_bad  = ((off48 >> h) != '0) || (off48 < ADDR_W'(HEADER_BYTES));
    blk_calc = off48[HEAP_ORDER_MAX-1:0] - HEAP_ORDER_MAX'(HEADER_BYTES);
    tmask    = ~({HEAP_ORDER_MAX{1'b1}} << tg_rdata);
    tag_bad  = (tg_rdata < ORDER_W'(MIN_ORDER)) || (tg_rdata > ORDER_W'(h)) ||
               ((blk & tmask) != '0);
    leaf_idx = (NODE_W'(1) << (h - ORD_W'(tg_rdata))) |
               NODE_W'(blk >> tg_rdata);
    tsize    = U_W'(1) << kord;
  end

  // Memory port control.
  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = nidx;
    fm_wdata = 1'b0;
    fm_raddr = nidx;
    tg_we    = 1'b0;
    tg_waddr = blk[HEAP_ORDER_MAX-1:MIN_ORDER];
    tg_wdata = '0;
    tg_raddr = blk_calc[HEAP_ORDER_MAX-1:MIN_ORDER];
    unique case (state)
      S_CLEAR: begin
        fm_we    = 1'b1;
        fm_waddr = ccnt;
        fm_wdata = (ccnt == NODE_W'(1));
        tg_we    = ~ccnt[NODE_W-1];
        tg_waddr = ccnt[GRAN_W-1:0];
      end
      S_A_CHK: begin
        fm_we = fm_rdata;
      end
      S_SPLIT: begin
        fm_we    = 1'b1;
        fm_waddr = {nidx[NODE_W-2:0], 1'b1};
        fm_wdata = 1'b1;
      end
      S_A_TAG: begin
        tg_we    = 1'b1;
        tg_waddr = off_blk[HEAP_ORDER_MAX-1:MIN_ORDER];
        tg_wdata = ORDER_W'(kord);
      end
      S_F_TAG: begin
        tg_we = ~tag_bad;
      end
      S_M_RD: begin
        fm_raddr = nidx ^ NODE_W'(1);
      end
      S_M_CHK: begin
        fm_we    = fm_rdata;
        fm_waddr = nidx ^ NODE_W'(1);
      end
      S_M_SET: begin
        fm_we    = 1'b1;
        fm_wdata = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      ccnt       <= '0;
      used_total <= '0;
      for (int j = 0; j < NORD; j++) begin
        cnt[j] <= '0;
      end
    end else if (start_clear) begin
      state <= S_CLEAR;
      ccnt  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            size_q <= in_size;
            ptr_q  <= in_ptr;
            state  <= (in_cmd == CMD_FREE) ? S_F_ADDR : S_A_SIZE;
          end
        end
        S_CLEAR: begin
          ccnt <= ccnt + NODE_W'(1);
          if (ccnt == {NODE_W{1'b1}}) begin
            for (int j = 0; j < NORD; j++) begin
              cnt[j] <= (ORD_W'(j) == h) ? CNT_W'(1) : '0;
            end
            used_total <= '0;
            state      <= S_IDLE;
          end
        end
        S_A_SIZE: begin
          kord <= k_calc;
          if (size_bad) begin
            res   <= '{block_order: '0, alloc_addr: '0, status: ST_BAD_SIZE};
            state <= S_DONE;
          end else begin
            state <= S_A_ORD;
          end
        end
        S_A_ORD: begin
          if (ord_found) begin
            ord   <= ord_first;
            nidx  <= NODE_W'(1) << (h - ord_first);
            state <= S_A_RD;
          end else begin
            res   <= '{block_order: '0, alloc_addr: '0, status: ST_NO_MEM};
            state <= S_DONE;
          end
        end
        S_A_RD: begin
          state <= S_A_CHK;
        end
        S_A_CHK: begin
          if (fm_rdata) begin
            cnt[ord] <= cnt[ord] - CNT_W'(1);
            state    <= (ord > kord) ? S_SPLIT : S_A_TAG;
          end else begin
            nidx  <= nidx + NODE_W'(1);
            state <= S_A_RD;
          end
        end
        S_SPLIT: begin
          cnt[ord - ORD_W'(1)] <= cnt[ord - ORD_W'(1)] + CNT_W'(1);
          ord  <= ord - ORD_W'(1);
          nidx <= {nidx[NODE_W-2:0], 1'b0};
          if (ord - ORD_W'(1) == kord) begin
            state <= S_A_TAG;
          end
        end
        S_A_TAG: begin
          used_total <= used_total + tsize;
          res <= '{block_order: ORDER_W'(kord),
                   alloc_addr:  base + ADDR_W'(off_blk) + ADDR_W'(HEADER_BYTES),
                   status:      ST_OK};
          state <= S_DONE;
        end
        S_F_ADDR: begin
          blk <= blk_calc;
          if (off_bad) begin
            res   <= '{block_order: '0, alloc_addr: '0, status: ST_BAD_ADDR};
            state <= S_DONE;
          end else if (blk_calc[MIN_ORDER-1:0] != '0) begin
            res   <= '{block_order: '0, alloc_addr: '0, status: ST_NOT_ALLOC};
            state <= S_DONE;
          end else begin
            state <= S_F_TAG;
          end
        end
        S_F_TAG: begin
          if (tag_bad) begin
            res   <= '{block_order: '0, alloc_addr: '0, status: ST_NOT_ALLOC};
            state <= S_DONE;
          end else begin
            kord  <= ORD_W'(tg_rdata);
            ord   <= ORD_W'(tg_rdata);
            nidx  <= leaf_idx;
            state <= S_M_RD;
          end
        end
        S_M_RD: begin
          state <= (ord < h) ? S_M_CHK : S_M_SET;
        end
        S_M_CHK: begin
          if (fm_rdata) begin
            cnt[ord] <= cnt[ord] - CNT_W'(1);
            nidx     <= nidx >> 1;
            ord      <= ord + ORD_W'(1);
            state    <= S_M_RD;
          end else begin
            state <= S_M_SET;
          end
        end
        S_M_SET: begin
          cnt[ord]   <= cnt[ord] + CNT_W'(1);
          used_total <= (used_total >= tsize) ? used_total - tsize : '0;
          res <= '{block_order: ORDER_W'(kord), alloc_addr: '0, status: ST_OK};
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for the buddy block allocator: directed and random requests.
`timescale 1ns / 1ps
// Requests enter on the slave stream; results leave on the master stream. A behavioral
// model of the allocator predicts every result when its request is accepted, and the
// result checker compares each result against the oldest prediction, field by field.
// The run walks several heap settings (clamped orders, wrapping bases), mixes directed
// corner requests with random allocate/free traffic, and stalls both sides at random.
module testbench;
  import bba_pkg::*;

  localparam int HMAX = 16;
  localparam int MINO = 5;
  localparam int HDR = 16;
  localparam int NODES = 1 << (HMAX - MINO + 1);
  localparam int GRAN = 1 << (HMAX - MINO);
  localparam logic [1:0] REG_SPARE = 2'd2;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [2:0]  status;
    logic [47:0] addr;
    logic [4:0]  order;
    logic [16:0] used;
    logic [16:0] free;
  } alloc_res_t;

  typedef struct {
    logic        cmd;
    logic [31:0] size;
    logic [47:0] ptr;
    bit          typed;   // the row carries its own status, pointer and order
    logic [2:0]  status;
    logic [47:0] addr;
    logic [4:0]  order;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_wdata = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [79:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [95:0] m_tdata;

  buddy_block_allocator_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Shadow copy of the heap state.
  logic [47:0] heap_base_m;
  logic [4:0]  heap_order_m;
  bit          node_free[NODES];
  logic [4:0]  granule_tag[GRAN];
  int unsigned used_total_m;
  logic [47:0] live_ptrs[$];

  alloc_res_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int n_requests = 0;
  int n_alloc_ok = 0;
  int n_free_ok = 0;
  int n_errors_seen = 0;
  bit stall_out = 0;   // request for a long receiver hold-off
  bit quiet = 0;       // stretch with no idling on either side

  function automatic int heap_h();
    if (heap_order_m < MINO) return MINO;
    if (heap_order_m > HMAX) return HMAX;
    return int'(heap_order_m);
  endfunction

  function automatic void clear_heap();
    foreach (node_free[i]) node_free[i] = 0;
    foreach (granule_tag[i]) granule_tag[i] = '0;
    node_free[1] = 1;
    used_total_m = 0;
    live_ptrs.delete();
  endfunction

  // Allocate: smallest fitting order, lowest free node searching upward, split down.
  function automatic void predict_alloc(logic [31:0] size, ref alloc_res_t r);
    int h, k, o, idx;
    longint unsigned need, off;
    h = heap_h();
    need = longint'(size) + HDR;
    if (size == 0 || need > (64'd1 << h)) begin
      r.status = ST_BAD_SIZE;
      return;
    end
    k = MINO;
    while ((64'd1 << k) < need) k++;
    for (o = k; o <= h; o++) begin
      for (int i = 0; i < (1 << (h - o)); i++) begin
        idx = (1 << (h - o)) + i;
        if (node_free[idx]) begin
          node_free[idx] = 0;
          while (o > k) begin
            o--;
            node_free[2 * idx + 1] = 1;
            idx = 2 * idx;
          end
          off = longint'(idx - (1 << (h - k))) << k;
          granule_tag[(off >> MINO) % GRAN] = 5'(k);
          used_total_m += 1 << k;
          r.status = ST_OK;
          r.addr = heap_base_m + off[47:0] + 48'(HDR);
          r.order = 5'(k);
          live_ptrs.push_back(r.addr);
          return;
        end
      end
    end
    r.status = ST_NO_MEM;
  endfunction

  // Free: validate the pointer, clear the tag, merge with free buddies upward.
  function automatic void predict_free(logic [47:0] ptr, ref alloc_res_t r);
    int h, t, o, idx;
    logic [47:0] off, blk;
    h = heap_h();
    off = ptr - heap_base_m;
    if (off >= (48'd1 << h) || off < HDR) begin
      r.status = ST_BAD_ADDR;
      return;
    end
    blk = off - 48'(HDR);
    t = int'(granule_tag[(blk >> MINO) % GRAN]);
    if (blk[MINO-1:0] != 0 || t < MINO || t > h || (blk & ((48'd1 << t) - 1)) != 0) begin
      r.status = ST_NOT_ALLOC;
      return;
    end
    granule_tag[(blk >> MINO) % GRAN] = '0;
    idx = (1 << (h - t)) | int'(blk >> t);
    o = t;
    while (o < h && node_free[idx ^ 1]) begin
      node_free[idx ^ 1] = 0;
      idx = idx >> 1;
      o++;
    end
    node_free[idx] = 1;
    used_total_m = (used_total_m >= (1 << t)) ? used_total_m - (1 << t) : 0;
    r.status = ST_OK;
    r.order = 5'(t);
    foreach (live_ptrs[i])
      if (live_ptrs[i] == ptr) begin
        live_ptrs.delete(i);
        break;
      end
  endfunction

  function automatic alloc_res_t predict_request(logic cmd, logic [31:0] size,
                                                 logic [47:0] ptr);
    alloc_res_t r;
    r = '{ST_OK, '0, '0, '0, '0};
    if (cmd == CMD_ALLOC) predict_alloc(size, r);
    else predict_free(ptr, r);
    if (r.status != ST_OK) begin
      r.addr = '0;
      r.order = '0;
    end
    r.used = 17'(used_total_m);
    r.free = 17'((1 << heap_h()) - used_total_m);
    return r;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random back-pressure, with a long hold-off when the sender asks for one.
  initial begin
    int held;
    forever begin
      @(negedge clk);
      if (stall_out) begin
        m_tready <= 0;
        for (held = 0; held < 400; held++) @(negedge clk);
        stall_out = 0;
      end
      m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 33);
    end
  end

  // Result checker: every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        alloc_res_t e;
        e = pending_results.pop_front();
        if (e.status != ST_OK) n_errors_seen++;
        if (m_tdata[2:0] !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[50:3] !== e.addr) begin
          $display("%0t: alloc_addr expected %h actual %h", $time, e.addr, m_tdata[50:3]);
          errors++;
        end
        if (m_tdata[55:51] !== e.order) begin
          $display("%0t: block_order expected %0d actual %0d", $time, e.order,
                   m_tdata[55:51]);
          errors++;
        end
        if (m_tdata[72:56] !== e.used) begin
          $display("%0t: used_bytes expected %0d actual %0d", $time, e.used,
                   m_tdata[72:56]);
          errors++;
        end
        if (m_tdata[89:73] !== e.free) begin
          $display("%0t: free_bytes expected %0d actual %0d", $time, e.free,
                   m_tdata[89:73]);
          errors++;
        end
      end
    end
  end

  // Offer one request, optionally after a random gap, and record its prediction on
  // acceptance. Typed rows replace the predicted status, pointer and order. Valid stays
  // high after acceptance; the next request replaces or drops it, or a drain takes it down.
  task automatic send_request(stim_row_t row);
    alloc_res_t r;
    if (!quiet && $urandom_range(99) < 33) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= row.cmd;
    s_tdata <= {row.ptr, row.size};
    do @(posedge clk); while (!s_tready);
    r = predict_request(row.cmd, row.size, row.ptr);
    if (row.typed) begin
      r.status = row.status;
      r.addr = row.addr;
      r.order = row.order;
    end
    pending_results.push_back(r);
    n_requests++;
    if (r.status == ST_OK && row.cmd == CMD_ALLOC) n_alloc_ok++;
    if (r.status == ST_OK && row.cmd == CMD_FREE) n_free_ok++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    wait (pending_results.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  // Register writes happen only with the block idle; any write to a real register
  // reinitializes the heap.
  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_HEAP_BASE) begin
      heap_base_m = val;
      clear_heap();
    end else if (idx == REG_HEAP_ORDER) begin
      heap_order_m = val[4:0];
      clear_heap();
    end
  endtask

  function automatic stim_row_t random_row();
    stim_row_t row;
    int h, r, pick;
    h = heap_h();
    row = '{CMD_ALLOC, '0, '0, 0, '0, '0, '0};
    row.ptr = 48'({$urandom, $urandom});
    row.size = $urandom;
    pick = $urandom_range(99);
    if (live_ptrs.size() == 0 || pick < 55) begin
      row.cmd = CMD_ALLOC;
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: row.size = 0;
          1: row.size = $urandom;
          default: row.size = 32'((1 << h) - HDR + 1);
        endcase
      end else begin
        // Keep most requests small on large heaps so the allocator scans stay short.
        r = $urandom_range(MINO, (h > 12 && $urandom_range(3) != 0) ? 12 : h);
        row.size = $urandom_range(1, (1 << r) - HDR);
      end
    end else begin
      row.cmd = CMD_FREE;
      pick = $urandom_range(99);
      if (pick < 65) row.ptr = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
      else if (pick < 80) row.ptr = live_ptrs[$urandom_range(live_ptrs.size() - 1)]
                                    + 48'($urandom_range(1, 63));
      else if (pick < 90) row.ptr = heap_base_m + 48'($urandom_range(0, (1 << h) + 64));
      else row.ptr = 48'({$urandom, $urandom});
    end
    return row;
  endfunction

  // Directed rows at reset settings (base 0, order 16).
  stim_row_t directed[] = '{
    '{CMD_ALLOC, 32'd0,          48'd0,      1, ST_BAD_SIZE,  48'd0,  5'd0},
    '{CMD_ALLOC, 32'd65521,      48'd0,      1, ST_BAD_SIZE,  48'd0,  5'd0},
    '{CMD_ALLOC, 32'hFFFF_FFFF,  48'd0,      1, ST_BAD_SIZE,  48'd0,  5'd0},
    '{CMD_ALLOC, 32'd65520,      48'd0,      1, ST_OK,        48'd16, 5'd16},
    '{CMD_ALLOC, 32'd1,          48'd0,      1, ST_NO_MEM,    48'd0,  5'd0},
    '{CMD_FREE,  32'd0,          48'd16,     1, ST_OK,        48'd0,  5'd16},
    '{CMD_FREE,  32'd0,          48'd0,      1, ST_BAD_ADDR,  48'd0,  5'd0},
    '{CMD_FREE,  32'd0,          48'd65536,  1, ST_BAD_ADDR,  48'd0,  5'd0},
    '{CMD_FREE,  32'd0,          '1,         1, ST_BAD_ADDR,  48'd0,  5'd0},
    '{CMD_FREE,  32'd0,          48'd17,     1, ST_NOT_ALLOC, 48'd0,  5'd0},
    '{CMD_FREE,  32'd0,          48'd48,     1, ST_NOT_ALLOC, 48'd0,  5'd0},
    '{CMD_ALLOC, 32'd1,          48'd0,      1, ST_OK,        48'd16, 5'd5},
    '{CMD_ALLOC, 32'd16,         48'd0,      1, ST_OK,        48'd48, 5'd5},
    '{CMD_ALLOC, 32'd17,         48'd0,      0, '0, '0, '0},
    '{CMD_ALLOC, 32'd4000,       48'd0,      0, '0, '0, '0},
    '{CMD_FREE,  32'd0,          48'd16,     1, ST_OK,        48'd0,  5'd5},
    '{CMD_FREE,  32'd0,          48'd16,     1, ST_NOT_ALLOC, 48'd0,  5'd0},
    '{CMD_FREE,  32'd0,          48'd48,     0, '0, '0, '0},
    '{CMD_FREE,  32'd0,          48'd80,     0, '0, '0, '0},
    '{CMD_FREE,  32'd0,          48'd144,    0, '0, '0, '0}
  };

  initial begin
    logic [47:0] bases[8];
    logic [4:0]  orders[8];
    heap_base_m = '0;
    heap_order_m = 5'd16;
    clear_heap();
    repeat (4) @(negedge clk);
    rst <= 0;

    foreach (directed[i]) send_request(directed[i]);

    // Heap settings per random phase: clamped orders at both ends and wrapping bases.
    bases  = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h1234_5678_0000, 48'h0,
               48'hFFFF_FFFF_FF00, 48'hABCD_EF01_2345, 48'h0000_8000_0000, 48'h5555_AAAA_0000};
    orders = '{5'd5, 5'd0, 5'd31, 5'd16, 5'd8, 5'd10, 5'd12, 5'd6};
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_SPARE, 48'({$urandom, $urandom}));
      write_reg(REG_HEAP_BASE, bases[p]);
      write_reg(REG_HEAP_ORDER, 48'(orders[p]));
      for (int n = 0; n < 92; n++) begin
        quiet = (p == 3 && n >= 20 && n < 60);
        if (p == 2 && n == 10) stall_out = 1;   // outputs back up while requests keep coming
        if (p == 5 && n == 40) drain();
        send_request(random_row());
      end
    end

    drain();
    $display("Ran %0d requests over 9 heap settings: %0d allocations and %0d frees succeeded,",
             n_requests, n_alloc_ok, n_free_ok);
    $display("%0d requests rejected with an error status.", n_errors_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_seq.sv
hdl/buddy_block_allocator_top.sv
tb/testbench.sv
